// File: hw/rtl/pulse_width_capture_buffer_defines.svh
// assertion macros for the checker file
`ifndef PULSE_WIDTH_CAPTURE_BUFFER_DEFINES_SVH
`define PULSE_WIDTH_CAPTURE_BUFFER_DEFINES_SVH

// same-cycle implication, off while reset is held
`define PWCB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define PWCB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pwcb_pkg.sv
// shared types and constants of the pulse width capture buffer
`timescale 1ns / 1ps

package pwcb_pkg;

    localparam int BUFFER_DEPTH_DEFAULT = 256;

    localparam int FUNC_W        = 2;
    localparam int TIME_W        = 32;
    localparam int INDEX_W       = 8;
    localparam int COUNT_OUT_W   = 9;
    localparam int PULSE_LIMIT_W = 20;
    localparam int TIMEOUT_W     = 16;
    localparam int MIN_COUNT_W   = 9;
    localparam int CFG_DATA_W    = 20;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [MIN_COUNT_W-1:0] MIN_COUNT_RESET = 9'd64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_EDGE  = 2'd0,
        FUNC_POLL  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ONE_MIN   = 3'd0,
        CFG_ONE_MAX   = 3'd1,
        CFG_ZERO_MIN  = 3'd2,
        CFG_ZERO_MAX  = 3'd3,
        CFG_TIMEOUT   = 3'd4,
        CFG_MIN_COUNT = 3'd5
    } t_cfg_index;

endpackage

// File: hw/rtl/pwcb_in_if.sv
// input channel: one edge, poll, clear or read word
`timescale 1ns / 1ps

interface pwcb_in_if;
    logic                          valid;
    logic                          ready;
    logic [pwcb_pkg::FUNC_W-1:0]   func;
    logic                          line_level;
    logic [pwcb_pkg::TIME_W-1:0]   time_us;
    logic [pwcb_pkg::TIME_W-1:0]   time_ms;
    logic [pwcb_pkg::INDEX_W-1:0]  read_index;

    modport source (output valid, func, line_level, time_us, time_ms, read_index,
                    input ready);
    modport sink   (input valid, func, line_level, time_us, time_ms, read_index,
                    output ready);
endinterface

// File: hw/rtl/pwcb_out_if.sv
// output channel: one result word per input word
`timescale 1ns / 1ps

interface pwcb_out_if;
    logic                              valid;
    logic                              ready;
    logic                              packet_ready;
    logic [pwcb_pkg::COUNT_OUT_W-1:0]  pulse_count;
    logic                              pulse_accepted;
    logic [pwcb_pkg::TIME_W-1:0]       entry_width;

    modport source (output valid, packet_ready, pulse_count, pulse_accepted, entry_width,
                    input ready);
    modport sink   (input valid, packet_ready, pulse_count, pulse_accepted, entry_width,
                    output ready);
endinterface

// File: hw/rtl/pwcb_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module pwcb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pulse_width_capture_buffer.sv
// top level of the pulse width capture buffer
`timescale 1ns / 1ps

// Measures high pulses on a demodulated on-off-keyed line. Each input word is
// a line edge, a poll, a clear or a read. A rising edge latches its microsecond
// time; a falling edge takes the width as a 32-bit wrapping difference and, while
// no packet is ready, stores it when it lies inside the one-window or the
// zero-window (bounds inclusive) and the buffer still has room, noting the
// millisecond time as the last pulse. A poll raises packet_ready once at least
// min_count widths are held and quiet_timeout_ms has passed since the last pulse.
// Clear empties the buffer and drops packet_ready. A read returns the stored
// width at read_index, or 0 when the index is at or beyond the count. Every word
// gives exactly one result word. One word is taken per clock cycle while the
// result side is not stalled. The input register takes each word, and once the
// result register is free or being drained, the result register and the buffer
// ram's registered read port take its result, which makes the result word valid.
// The buffer ram sees at most one write and one read per word. pulse_count shows
// the low 9 bits of the count. The user must write configuration registers only
// while no word is in flight; the block itself does not enforce this.

module pulse_width_capture_buffer #(
    parameter int BUFFER_DEPTH = pwcb_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    pwcb_in_if.sink                              i_in,
    pwcb_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [pwcb_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [pwcb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    // configuration registers
    logic [pwcb_pkg::PULSE_LIMIT_W-1:0] r_one_min;
    logic [pwcb_pkg::PULSE_LIMIT_W-1:0] r_one_max;
    logic [pwcb_pkg::PULSE_LIMIT_W-1:0] r_zero_min;
    logic [pwcb_pkg::PULSE_LIMIT_W-1:0] r_zero_max;
    logic [pwcb_pkg::TIMEOUT_W-1:0]     r_timeout;
    logic [pwcb_pkg::MIN_COUNT_W-1:0]   r_min_count;

    // input register stage
    logic                           r_s1_valid;
    pwcb_pkg::t_func                r_func;
    logic                           r_level;
    logic [pwcb_pkg::TIME_W-1:0]    r_time_us;
    logic [pwcb_pkg::TIME_W-1:0]    r_time_ms;
    logic [pwcb_pkg::INDEX_W-1:0]   r_read_index;

    // capture state
    logic [pwcb_pkg::TIME_W-1:0]    r_rise_time;
    logic [pwcb_pkg::TIME_W-1:0]    r_last_pulse;
    logic [CW-1:0]                  r_count;
    logic                           r_ready_flag;

    // result register stage
    logic                              r_s2_valid;
    logic                              r_o_ready;
    logic [pwcb_pkg::COUNT_OUT_W-1:0]  r_o_count;
    logic                              r_o_accepted;
    logic                              r_o_hit;

    // next values
    logic [pwcb_pkg::TIME_W-1:0]    n_rise_time;
    logic [pwcb_pkg::TIME_W-1:0]    n_last_pulse;
    logic [CW-1:0]                  n_count;
    logic                           n_ready_flag;
    logic                           n_accepted;
    logic                           n_hit;

    logic                           s1_adv;
    logic                           in_take;
    logic [pwcb_pkg::TIME_W-1:0]    width;
    logic [pwcb_pkg::TIME_W-1:0]    quiet;
    logic                           in_one_win;
    logic                           in_zero_win;
    logic                           has_room;
    logic                           ram_we;
    logic [AW-1:0]                  ram_raddr;
    logic [pwcb_pkg::TIME_W-1:0]    ram_rdata;
    logic [31:0]                    read_index_ext;

    // stage one moves on when the result register is free or being drained
    assign s1_adv     = r_s1_valid && (!r_s2_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_take    = i_in.valid && i_in.ready;

    // pulse width and window checks, 32-bit wrapping
    assign width       = r_time_us - r_rise_time;
    assign quiet       = r_time_ms - r_last_pulse;
    assign in_one_win  = (width >= 32'(r_one_min)) && (width <= 32'(r_one_max));
    assign in_zero_win = (width >= 32'(r_zero_min)) && (width <= 32'(r_zero_max));
    assign has_room    = 32'(r_count) < 32'(BUFFER_DEPTH);

    // read address; indexes past the depth are masked by the count compare
    assign read_index_ext = 32'(r_read_index);
    assign ram_raddr      = read_index_ext[AW-1:0];

    always_comb begin
        n_rise_time  = r_rise_time;
        n_last_pulse = r_last_pulse;
        n_count      = r_count;
        n_ready_flag = r_ready_flag;
        n_accepted   = 1'b0;
        n_hit        = 1'b0;
        case (r_func)
            pwcb_pkg::FUNC_EDGE: begin
                if (r_level) begin
                    n_rise_time = r_time_us;
                end else if (!r_ready_flag && (in_one_win || in_zero_win) && has_room) begin
                    n_count      = CW'(r_count + 1'b1);
                    n_last_pulse = r_time_ms;
                    n_accepted   = 1'b1;
                end
            end
            pwcb_pkg::FUNC_POLL: begin
                if (!r_ready_flag && (32'(r_count) >= 32'(r_min_count))
                        && (quiet >= 32'(r_timeout))) begin
                    n_ready_flag = 1'b1;
                end
            end
            pwcb_pkg::FUNC_CLEAR: begin
                n_count      = '0;
                n_ready_flag = 1'b0;
            end
            pwcb_pkg::FUNC_READ: begin
                n_hit = read_index_ext < 32'(r_count);
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
    end

    // a stored width goes to the slot at the current count
    assign ram_we = s1_adv && n_accepted;

    pwcb_ram #(
        .WIDTH (pwcb_pkg::TIME_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (width),
        .i_re    (s1_adv),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_min   <= '0;
            r_one_max   <= '0;
            r_zero_min  <= '0;
            r_zero_max  <= '0;
            r_timeout   <= '0;
            r_min_count <= pwcb_pkg::MIN_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (pwcb_pkg::t_cfg_index'(i_cfg_index))
                pwcb_pkg::CFG_ONE_MIN:   r_one_min   <= i_cfg_data;
                pwcb_pkg::CFG_ONE_MAX:   r_one_max   <= i_cfg_data;
                pwcb_pkg::CFG_ZERO_MIN:  r_zero_min  <= i_cfg_data;
                pwcb_pkg::CFG_ZERO_MAX:  r_zero_max  <= i_cfg_data;
                pwcb_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data[pwcb_pkg::TIMEOUT_W-1:0];
                pwcb_pkg::CFG_MIN_COUNT: r_min_count <= i_cfg_data[pwcb_pkg::MIN_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func       <= pwcb_pkg::t_func'(i_in.func);
            r_level      <= i_in.line_level;
            r_time_us    <= i_in.time_us;
            r_time_ms    <= i_in.time_ms;
            r_read_index <= i_in.read_index;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_ready    <= n_ready_flag;
            r_o_count    <= pwcb_pkg::COUNT_OUT_W'(n_count);
            r_o_accepted <= n_accepted;
            r_o_hit      <= n_hit;
        end
    end

    // control and capture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_rise_time  <= '0;
            r_last_pulse <= '0;
            r_count      <= '0;
            r_ready_flag <= 1'b0;
        end else begin
            r_s1_valid <= in_take || (r_s1_valid && !s1_adv);
            r_s2_valid <= s1_adv || (r_s2_valid && !o_out.ready);
            if (s1_adv) begin
                r_rise_time  <= n_rise_time;
                r_last_pulse <= n_last_pulse;
                r_count      <= n_count;
                r_ready_flag <= n_ready_flag;
            end
        end
    end

    // result word; ram data holds while the result waits
    assign o_out.valid          = r_s2_valid;
    assign o_out.packet_ready   = r_o_ready;
    assign o_out.pulse_count    = r_o_count;
    assign o_out.pulse_accepted = r_o_accepted;
    assign o_out.entry_width    = r_o_hit ? ram_rdata : '0;

endmodule

// File: hw/rtl/pwcb_checker.sv
// port-level checks of the pulse width capture buffer and their bind
`timescale 1ns / 1ps
`include "pulse_width_capture_buffer_defines.svh"

module pwcb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_packet_ready,
    input logic [pwcb_pkg::COUNT_OUT_W-1:0]  i_pulse_count,
    input logic                              i_pulse_accepted,
    input logic [pwcb_pkg::TIME_W-1:0]       i_entry_width
);

    // a width is only stored while no packet is ready
    `PWCB_ASSERT_IMP(a_accept_not_ready, i_clk, i_rst_n, i_out_valid && i_pulse_accepted, !i_packet_ready, "stored a width while packet ready")

    // an accepting edge is no read, so it carries no entry width
    `PWCB_ASSERT_IMP(a_accept_no_entry, i_clk, i_rst_n, i_out_valid && i_pulse_accepted, i_entry_width == '0, "edge result carries an entry width")

    // a stalled result word holds
    `PWCB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_packet_ready) && $stable(i_pulse_count) && $stable(i_pulse_accepted) && $stable(i_entry_width), "stalled result word changed")

endmodule

bind pulse_width_capture_buffer pwcb_checker u_pwcb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_packet_ready   (o_out.packet_ready),
    .i_pulse_count    (o_out.pulse_count),
    .i_pulse_accepted (o_out.pulse_accepted),
    .i_entry_width    (o_out.entry_width)
);
